[sv/sdmux_pkg.sv]
// shared types and constants for the four-digit segment display mux
// no dependencies
`default_nettype none

package sdmux_pkg;

  typedef enum logic {
    OpLoad = 1'b0,
    OpTick = 1'b1
  } opcode_e;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned SegW      = 8;
  localparam int unsigned ValueW    = 16;

  localparam logic [SegW-1:0] SegBlank = 8'hFF;

  // reciprocal constants for exact division of values below 2^15
  localparam logic [15:0] RecipTen      = 16'd52429;
  localparam int unsigned ShiftTen      = 19;
  localparam logic [15:0] RecipHundred  = 16'd20972;
  localparam int unsigned ShiftHundred  = 21;
  localparam logic [15:0] RecipThousand = 16'd33555;
  localparam int unsigned ShiftThousand = 25;

  typedef logic [SegW-1:0] seg_t;

  // active-low pattern, bit0 segment a; anything above nine is blank
  function automatic seg_t encode_digit(input logic [5:0] d);
    seg_t s;
    case (d)
      6'd0:    s = 8'hC0;
      6'd1:    s = 8'hF9;
      6'd2:    s = 8'hA4;
      6'd3:    s = 8'hB0;
      6'd4:    s = 8'h99;
      6'd5:    s = 8'h92;
      6'd6:    s = 8'h82;
      6'd7:    s = 8'hF8;
      6'd8:    s = 8'h80;
      6'd9:    s = 8'h90;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/four_digit_segment_display_mux_core.sv]
// four-digit multiplexed seven-segment display driver, top level
// depends on sdmux_pkg
//
// usage:
//   slave stream: tuser carries the opcode (0 load, 1 tick), tdata the
//   signed 16-bit number, read only by load items
//   master stream: one item per input item; tdata bits 7:0 hold the
//   active-low segment pattern, bits 11:8 the one-hot digit select
//   a load splits the number into four decimal digits, stores their
//   patterns (negative numbers and out-of-range thousands blank) and
//   returns a blank item with no digit selected; a tick returns the
//   pattern of the current digit, ones first, and moves to the next
//   an accepted item passes the input register, then the result register
//   throughput: one item per cycle unless tready stalls; the decimal split is three
//   constant reciprocal multiplies between the input and result regs
//   reset: all digits blank, scan at the ones digit, both stages empty
//   stall: the result register holds while tready is low; the input
//   register still takes one more item, then tready drops
`default_nettype none

module four_digit_segment_display_mux_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // value[15:0]
  input  wire logic        s_axis_tuser_i,  // opcode[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o   // segments[7:0], digit_select[11:8], zero[15:12]
);

  import sdmux_pkg::*;

  logic                     in_valid_q;
  opcode_e                  op_q;
  logic [ValueW-1:0]        value_q;
  seg_t                     pat_q [NumDigits];
  seg_t                     pat_d [NumDigits];
  logic [1:0]               scan_q;
  logic [1:0]               scan_d;
  logic                     out_valid_q;
  seg_t                     seg_q;
  seg_t                     seg_d;
  logic [NumDigits-1:0]     sel_q;
  logic [NumDigits-1:0]     sel_d;
  logic                     out_free;
  logic                     proc;
  logic [14:0]              n;
  logic [30:0]              prod1;
  logic [30:0]              prod2;
  logic [30:0]              prod3;
  logic [11:0]              q1;
  logic [8:0]               q2;
  logic [5:0]               q3;
  logic [14:0]              ones;
  logic [11:0]              tens;
  logic [8:0]               hundreds;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  // decimal split by constant reciprocals
  assign n     = value_q[14:0];
  assign prod1 = 31'(n) * 31'(RecipTen);
  assign prod2 = 31'(n) * 31'(RecipHundred);
  assign prod3 = 31'(n) * 31'(RecipThousand);
  assign q1    = 12'(prod1 >> ShiftTen);
  assign q2    = 9'(prod2 >> ShiftHundred);
  assign q3    = 6'(prod3 >> ShiftThousand);

  assign ones     = n - ((15'(q1) << 3) + (15'(q1) << 1));
  assign tens     = q1 - ((12'(q2) << 3) + (12'(q2) << 1));
  assign hundreds = q2 - ((9'(q3) << 3) + (9'(q3) << 1));

  always_comb begin
    pat_d  = pat_q;
    scan_d = scan_q;
    seg_d  = seg_q;
    sel_d  = sel_q;
    if (proc) begin
      case (op_q)
        OpLoad: begin
          if (value_q[ValueW-1]) begin
            for (int i = 0; i < NumDigits; i++) begin
              pat_d[i] = SegBlank;
            end
          end else begin
            pat_d[0] = encode_digit(6'(ones));
            pat_d[1] = encode_digit(6'(tens));
            pat_d[2] = encode_digit(6'(hundreds));
            pat_d[3] = encode_digit(q3);
          end
          scan_d = '0;
          seg_d  = SegBlank;
          sel_d  = '0;
        end
        OpTick: begin
          seg_d  = pat_q[scan_q];
          sel_d  = NumDigits'(1) << scan_q;
          scan_d = scan_q + 2'd1;
        end
        default: begin
          seg_d = SegBlank;
          sel_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      for (int i = 0; i < NumDigits; i++) begin
        pat_q[i] <= SegBlank;
      end
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      scan_q <= scan_d;
      pat_q  <= pat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      op_q    <= opcode_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i;
    end
    seg_q <= seg_d;
    sel_q <= sel_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, sel_q, seg_q};

  a_sel_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(sel_q))
    else $error("digit select not one-hot");

  a_none_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && sel_q == '0) |-> seg_q == SegBlank)
    else $error("unselected item not blank");

  a_tready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input side stalled without output stall");

  a_tick_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && op_q == OpTick) |=> scan_q == 2'($past(scan_q) + 2'd1))
    else $error("scan did not advance on tick");

  a_load_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && op_q == OpLoad) |=> (scan_q == '0 && sel_q == '0))
    else $error("load did not restart scan");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for four_digit_segment_display_mux_core
// predicts each output item from its own copy of the digit store and scan state
// depends on sdmux_pkg and the core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdmux_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 80;

  typedef struct packed {
    seg_t       seg;
    logic [3:0] sel;
  } shown_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  shown_item_t shown_q[$];
  shown_item_t want;
  seg_t        digit_glyphs[NumDigits];
  logic [1:0]  scan_pos;

  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_len = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned ready_mode = 0;

  four_digit_segment_display_mux_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic seg_t glyph_of(input int unsigned d);
    case (d)
      0:       return 8'hC0;
      1:       return 8'hF9;
      2:       return 8'hA4;
      3:       return 8'hB0;
      4:       return 8'h99;
      5:       return 8'h92;
      6:       return 8'h82;
      7:       return 8'hF8;
      8:       return 8'h80;
      9:       return 8'h90;
      default: return SegBlank;
    endcase
  endfunction

  task automatic predict_display(input opcode_e op, input logic [15:0] value);
    int unsigned n;
    shown_item_t r;
    if (op == OpLoad) begin
      if (value[15]) begin
        for (int i = 0; i < NumDigits; i++) digit_glyphs[i] = SegBlank;
      end else begin
        n = value;
        digit_glyphs[0] = glyph_of(n % 10);
        digit_glyphs[1] = glyph_of((n / 10) % 10);
        digit_glyphs[2] = glyph_of((n / 100) % 10);
        digit_glyphs[3] = glyph_of(n / 1000);
      end
      scan_pos = 2'd0;
      r.seg = SegBlank;
      r.sel = 4'b0000;
    end else begin
      r.seg = digit_glyphs[scan_pos];
      r.sel = 4'b0001 << scan_pos;
      scan_pos = scan_pos + 2'd1;
    end
    shown_q.push_back(r);
  endtask

  task automatic send_item(input opcode_e op, input logic [15:0] value);
    @(negedge clk);
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    predict_display(op, value);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom_range(0, 9));
      1:       return 16'($urandom_range(0, 99));
      2:       return 16'($urandom_range(0, 9999));
      3:       return 16'($urandom_range(10000, 32767));
      4:       return 16'h8000 | 16'($urandom);
      5: begin
        case ($urandom_range(0, 5))
          0:       return 16'd0;
          1:       return 16'd9999;
          2:       return 16'd10000;
          3:       return 16'h7FFF;
          4:       return 16'hFFFF;
          default: return 16'h8000;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random ready pattern, or a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 40);
      end
      mode_left--;
      case (ready_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= $urandom_range(0, 1);
        2:       m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (shown_q.size() == 0) begin
        $error("unexpected item: tdata %h", m_tdata);
        errors++;
      end else begin
        want = shown_q.pop_front();
        if (m_tdata[7:0] !== want.seg) begin
          $error("segments: expected %h, actual %h", want.seg, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[11:8] !== want.sel) begin
          $error("digit_select: expected %b, actual %b", want.sel, m_tdata[11:8]);
          errors++;
        end
        if (m_tdata[15:12] !== 4'b0000) begin
          $error("tdata padding: expected %b, actual %b", 4'b0000, m_tdata[15:12]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
      stall_cycles = 0;
    end else if (rst_n) begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_reset_scan();
    repeat (5) send_item(OpTick, 16'($urandom));
  endtask

  task automatic test_digit_glyphs();
    send_item(OpLoad, 16'd5432);
    repeat (4) send_item(OpTick, 16'($urandom));
    send_item(OpLoad, 16'd9876);
    repeat (4) send_item(OpTick, 16'($urandom));
  endtask

  task automatic test_range_edges();
    send_item(OpLoad, 16'd32701);
    repeat (4) send_item(OpTick, 16'h0000);
    send_item(OpLoad, 16'h8000);
    send_item(OpTick, 16'hFFFF);
    send_item(OpLoad, 16'd0);
    send_item(OpTick, 16'h0000);
    send_item(OpLoad, 16'hFFFF);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = LongHold;
    send_item(OpLoad, 16'd8051);
    repeat (23) send_item(OpTick, 16'($urandom));
    idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    opcode_e op;
    for (int i = 0; i < 800; i++) begin
      idle_on = ((i / 100) % 4) != 3;
      op = ($urandom_range(0, 3) == 0) ? OpLoad : OpTick;
      send_item(op, (op == OpLoad) ? rand_value() : 16'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NumDigits; i++) digit_glyphs[i] = SegBlank;
    scan_pos = 2'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_scan();
    test_digit_glyphs();
    test_range_edges();
    test_backpressure();
    test_random_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (shown_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sdmux_pkg.sv
sv/four_digit_segment_display_mux_core.sv
tb/sv/testbench.sv
